/* design/metr_pkg.sv */
`timescale 1ns / 1ps

package metr_pkg;

   localparam int IDX_W      = 3;
   localparam int ANGLE_W    = 15;
   localparam int NARROW_W   = 13;
   localparam int WORD_W     = 16;
   localparam int TOTAL_W    = 32;
   localparam int FCOUNT_W   = 8;
   localparam int MASK_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_WIDE_MASK = 3'd0;

   localparam logic signed [WORD_W:0] WIDE_COUNTS   = 17'sd32768;
   localparam logic signed [WORD_W:0] NARROW_COUNTS = 17'sd8192;
   localparam logic signed [WORD_W-1:0] WIDE_HALF   = 16'sd16384;
   localparam logic signed [WORD_W-1:0] NARROW_HALF = 16'sd4096;
   localparam int WIDE_SHIFT   = 15;
   localparam int NARROW_SHIFT = 13;

   // x/5 for x < 2^17 as (x * 52429) >> 18
   localparam logic [WORD_W-1:0] DIV5_RECIP = 16'd52429;
   localparam int DIV5_SHIFT = 18;

   typedef struct packed {
      logic [FCOUNT_W-1:0]      frame_count;
      logic [ANGLE_W-1:0]       last_angle;
      logic signed [WORD_W-1:0] turn_count;
      logic [ANGLE_W-1:0]       offset_angle;
   } entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

endpackage

/* design/motor_encoder_multiturn_tracker_unit.sv */
`timescale 1ns / 1ps

// Multi-turn encoder tracker. Each request word (motor index, raw angle, speed,
// current) produces one response word. Per-motor state lives in a small
// synchronous RAM: a word is accepted (RAM read), and the compute cycle after
// it writes the entry back and loads the output register; no new word is
// accepted until that load, and a stalled response holds the compute cycle.
// A new request is accepted while the previous response waits in the output
// register. Table entries read as zero until first written (per-entry valid
// flags), so no clearing pass is needed after reset. The first CALIB_LIMIT+1
// frames of a motor capture its offset.
// Bit m of the wide encoder register (address 0) selects 32768-count handling
// for motor m.
module motor_encoder_multiturn_tracker_unit
   import metr_pkg::*;
#(
   parameter int MOTORS      = 8,
   parameter int CALIB_LIMIT = 50
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [IDX_W-1:0]             req_motor_index,
   input  logic [ANGLE_W-1:0]           req_raw_angle,
   input  logic signed [WORD_W-1:0]     req_raw_speed,
   input  logic signed [WORD_W-1:0]     req_raw_current,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [IDX_W-1:0]             rsp_out_motor,
   output logic                         rsp_calibrating,
   output logic [ANGLE_W-1:0]           rsp_angle_now,
   output logic signed [WORD_W-1:0]     rsp_angle_step,
   output logic signed [TOTAL_W-1:0]    rsp_total_angle,
   output logic signed [WORD_W-1:0]     rsp_speed_out,
   output logic signed [WORD_W-1:0]     rsp_current_out,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

   state_type state_ff, state_in;

   logic [MASK_W-1:0] mask_ff;

   entry_type         mem [MOTORS];
   entry_type         rd_entry_ff;
   logic              rd_valid_ff;
   logic [MOTORS-1:0] valid_ff;

   logic [IDX_W-1:0]         item_idx_ff;
   logic [ANGLE_W-1:0]       item_angle_ff;
   logic signed [WORD_W-1:0] item_speed_ff;
   logic signed [WORD_W-1:0] item_current_ff;
   logic                     item_in_range_ff;

   logic [AW-1:0] req_addr;
   logic [AW-1:0] item_addr;
   logic          req_in_range;
   logic          accept;
   logic          load;
   logic          wr_en;

   entry_type                 entry;
   entry_type                 wr_entry;
   logic                      wide;
   logic                      calib;
   logic [ANGLE_W-1:0]        ang;
   logic signed [WORD_W-1:0]  diff;
   logic signed [WORD_W-1:0]  half;
   logic signed [WORD_W:0]    counts;
   logic signed [WORD_W:0]    step_wide;
   logic signed [WORD_W-1:0]  turns;
   logic signed [TOTAL_W-1:0] turn_ext;
   logic signed [TOTAL_W-1:0] turn_scaled;
   logic signed [TOTAL_W-1:0] total;
   logic signed [WORD_W+1:0]  spd3;
   logic [WORD_W:0]           spd_mag;
   logic [2*WORD_W:0]         spd_prod;
   logic [WORD_W-2:0]         spd_quot;
   logic signed [WORD_W-1:0]  spd_scaled;

   logic                      rsp_valid_ff;
   logic [IDX_W-1:0]          rsp_motor_ff;
   logic                      rsp_calib_ff,  rsp_calib_in;
   logic [ANGLE_W-1:0]        rsp_angle_ff,  rsp_angle_in;
   logic signed [WORD_W-1:0]  rsp_step_ff,   rsp_step_in;
   logic signed [TOTAL_W-1:0] rsp_total_ff,  rsp_total_in;
   logic signed [WORD_W-1:0]  rsp_speed_ff,  rsp_speed_in;
   logic signed [WORD_W-1:0]  rsp_cur_ff,    rsp_cur_in;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_WIDE_MASK[CSR_ADDR_W-1])
                       ? {{(CSR_DATA_W-MASK_W){1'b0}}, mask_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[CSR_ADDR_W-1] == CSR_WIDE_MASK[CSR_ADDR_W-1]) begin
         mask_ff <= csr_pwdata[MASK_W-1:0];
      end
   end

   // control
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept       = req_valid && req_ready;
   assign req_addr     = AW'(req_motor_index);
   assign item_addr    = AW'(item_idx_ff);
   assign req_in_range = 32'(req_motor_index) < MOTORS;
   assign wr_en        = load && item_in_range_ff;

   // table
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_entry_ff <= mem[req_addr];
      end
      if (wr_en) begin
         mem[item_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[item_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_valid_ff      <= req_in_range && valid_ff[req_addr];
         item_idx_ff      <= req_motor_index;
         item_angle_ff    <= req_raw_angle;
         item_speed_ff    <= req_raw_speed;
         item_current_ff  <= req_raw_current;
         item_in_range_ff <= req_in_range;
      end
   end

   // update
   always_comb begin
      entry  = rd_valid_ff ? rd_entry_ff : '0;
      wide   = mask_ff[item_idx_ff];
      ang    = wide ? item_angle_ff
                    : {{(ANGLE_W-NARROW_W){1'b0}}, item_angle_ff[NARROW_W-1:0]};
      calib  = entry.frame_count <= FCOUNT_W'(CALIB_LIMIT);
      half   = wide ? WIDE_HALF : NARROW_HALF;
      counts = wide ? WIDE_COUNTS : NARROW_COUNTS;
      diff   = $signed({1'b0, ang}) - $signed({1'b0, entry.last_angle});

      turns     = entry.turn_count;
      step_wide = {diff[WORD_W-1], diff};
      if (diff > half) begin
         if (turns != {1'b1, {(WORD_W-1){1'b0}}}) begin
            turns = turns - 16'sd1;
         end
         step_wide = {diff[WORD_W-1], diff} - counts;
      end else if (diff < -half) begin
         if (turns != {1'b0, {(WORD_W-1){1'b1}}}) begin
            turns = turns + 16'sd1;
         end
         step_wide = {diff[WORD_W-1], diff} + counts;
      end

      turn_ext    = {{(TOTAL_W-WORD_W){turns[WORD_W-1]}}, turns};
      turn_scaled = wide ? (turn_ext <<< WIDE_SHIFT) : (turn_ext <<< NARROW_SHIFT);
      total       = turn_scaled + $signed({{(TOTAL_W-ANGLE_W){1'b0}}, ang});
      if (wide) begin
         total = total - $signed({{(TOTAL_W-ANGLE_W){1'b0}}, entry.offset_angle});
      end

      spd3       = {{2{item_speed_ff[WORD_W-1]}}, item_speed_ff}
                 + {item_speed_ff[WORD_W-1], item_speed_ff, 1'b0};
      spd_mag    = spd3[WORD_W+1] ? (WORD_W+1)'(0) - spd3[WORD_W:0] : spd3[WORD_W:0];
      spd_prod   = spd_mag * DIV5_RECIP;
      spd_quot   = spd_prod[DIV5_SHIFT +: (WORD_W-1)];
      spd_scaled = spd3[WORD_W+1] ? -$signed({1'b0, spd_quot}) : $signed({1'b0, spd_quot});

      wr_entry            = entry;
      wr_entry.last_angle = ang;
      if (calib) begin
         wr_entry.offset_angle = ang;
         wr_entry.frame_count  = entry.frame_count + 8'd1;
      end else begin
         wr_entry.turn_count = turns;
      end

      rsp_calib_in = 1'b0;
      rsp_angle_in = '0;
      rsp_step_in  = '0;
      rsp_total_in = '0;
      rsp_speed_in = '0;
      rsp_cur_in   = '0;
      if (item_in_range_ff) begin
         rsp_angle_in = ang;
         if (calib) begin
            rsp_calib_in = 1'b1;
         end else begin
            rsp_step_in  = step_wide[WORD_W-1:0];
            rsp_total_in = total;
            rsp_speed_in = wide ? spd_scaled : item_speed_ff;
            rsp_cur_in   = item_current_ff;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_motor_ff <= item_idx_ff;
         rsp_calib_ff <= rsp_calib_in;
         rsp_angle_ff <= rsp_angle_in;
         rsp_step_ff  <= rsp_step_in;
         rsp_total_ff <= rsp_total_in;
         rsp_speed_ff <= rsp_speed_in;
         rsp_cur_ff   <= rsp_cur_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_motor   = rsp_motor_ff;
   assign rsp_calibrating = rsp_calib_ff;
   assign rsp_angle_now   = rsp_angle_ff;
   assign rsp_angle_step  = rsp_step_ff;
   assign rsp_total_angle = rsp_total_ff;
   assign rsp_speed_out   = rsp_speed_ff;
   assign rsp_current_out = rsp_cur_ff;

endmodule

/* design/metr_checker.sv */
`timescale 1ns / 1ps

module metr_checker
   import metr_pkg::*;
#(
   parameter int MOTORS = 8
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [IDX_W-1:0]          rsp_out_motor,
   input logic                      rsp_calibrating,
   input logic [ANGLE_W-1:0]        rsp_angle_now,
   input logic signed [WORD_W-1:0]  rsp_angle_step,
   input logic signed [TOTAL_W-1:0] rsp_total_angle,
   input logic signed [WORD_W-1:0]  rsp_speed_out,
   input logic signed [WORD_W-1:0]  rsp_current_out
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_motor) &&
      $stable(rsp_angle_now) && $stable(rsp_total_angle) && $stable(rsp_speed_out))
      else $error("response word changed while stalled");

   // one word in flight: busy right after accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous word in flight");

   // accepted word is loaded in the cycle after accept when the slot is free
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("response missing after free output slot");

   a_calib_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> rsp_angle_step == 0 &&
      rsp_total_angle == 0 && rsp_speed_out == 0 && rsp_current_out == 0)
      else $error("nonzero fields during offset capture");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && 32'(rsp_out_motor) >= MOTORS |-> !rsp_calibrating &&
      rsp_angle_now == 0 && rsp_total_angle == 0 && rsp_speed_out == 0)
      else $error("nonzero fields for motor outside table");

endmodule

bind motor_encoder_multiturn_tracker_unit metr_checker #(.MOTORS(MOTORS)) u_metr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_motor   (rsp_out_motor),
   .rsp_calibrating (rsp_calibrating),
   .rsp_angle_now   (rsp_angle_now),
   .rsp_angle_step  (rsp_angle_step),
   .rsp_total_angle (rsp_total_angle),
   .rsp_speed_out   (rsp_speed_out),
   .rsp_current_out (rsp_current_out)
);
